// ===== hw/rtl/npcm_pkg.sv =====
// Shared widths, defaults and the channel rank function of the nearest palette color match unit.
// No dependencies; the interfaces and the top level import this package.
`default_nettype none

package npcm_pkg;

  localparam int CHAN_W            = 16;
  localparam int INDEX_W           = 8;
  localparam int DIST_SHIFT        = 8;
  localparam int RANK_W            = 6;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int CHANNEL_BITS_DEF  = 16;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  // The ranks of red, green and blue (1 = largest) in two bits each, found by
  // strict compares in a fixed decision tree.
  function automatic logic [RANK_W-1:0] rank_code(input logic [CHAN_W-1:0] r,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] b);
    logic [1:0] rr;
    logic [1:0] gr;
    logic [1:0] br;
    if (r > g) begin
      if (r > b) begin
        rr = 2'd1;
        if (g > b) begin
          gr = 2'd2;
          br = 2'd3;
        end else begin
          br = 2'd2;
          gr = 2'd3;
        end
      end else begin
        br = 2'd1;
        rr = 2'd2;
        gr = 2'd3;
      end
    end else begin
      if (g > b) begin
        gr = 2'd1;
        if (r > b) begin
          rr = 2'd2;
          br = 2'd3;
        end else begin
          br = 2'd2;
          rr = 2'd3;
        end
      end else begin
        br = 2'd1;
        gr = 2'd2;
        rr = 2'd3;
      end
    end
    return {rr, gr, br};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/npcm_if.sv =====
// Request and result channel interfaces of the nearest palette color match unit.
// Depends on npcm_pkg for the field widths.
`default_nettype none

interface npcm_in_if;
  import npcm_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [INDEX_W-1:0] entry_index;
  logic [CHAN_W-1:0]  red;
  logic [CHAN_W-1:0]  green;
  logic [CHAN_W-1:0]  blue;
  logic               entry_available;

  modport source(output valid, kind, entry_index, red, green, blue, entry_available,
                 input ready);
  modport sink(input valid, kind, entry_index, red, green, blue, entry_available,
               output ready);
endinterface

interface npcm_out_if;
  import npcm_pkg::*;

  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] match_index;
  logic [CHAN_W-1:0]  match_red;
  logic [CHAN_W-1:0]  match_green;
  logic [CHAN_W-1:0]  match_blue;
  logic               found;
  logic               same_order;

  modport source(output valid, match_index, match_red, match_green, match_blue, found,
                 same_order, input ready);
  modport sink(input valid, match_index, match_red, match_green, match_blue, found,
               same_order, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/nearest_palette_color_match_unit.sv =====
// Top level of the nearest palette color match unit: palette memory, scan sequencer and distance unit.
// Depends on npcm_pkg and on the channel interfaces in npcm_if.sv.
`default_nettype none

// After reset the unit clears the palette, one entry a cycle, and takes no request meanwhile.
// A write request is stored in the palette as it is accepted, and the unit stays ready. A query
// reads the palette through the single read port of the memory, one entry a cycle, into a
// pipelined distance unit, and no request is taken until the scan is done. The result waits in an
// output register, and new requests are taken while it waits.
module nearest_palette_color_match_unit #(
  parameter int PALETTE_DEPTH = npcm_pkg::PALETTE_DEPTH_DEF,
  parameter int CHANNEL_BITS  = npcm_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  npcm_in_if.sink         in_chan,
  npcm_out_if.source      out_chan
);
  import npcm_pkg::*;

  localparam int AW    = $clog2(PALETTE_DEPTH);
  localparam int CB    = CHANNEL_BITS;
  localparam int MEM_W = 3 * CB + 1;
  localparam int MW    = CB - DIST_SHIFT + 1;
  localparam int SQW   = 2 * MW;
  localparam int DW    = SQW + 2;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [MEM_W-1:0] mem [PALETTE_DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [MEM_W-1:0] rd_data_r;

  logic [AW-1:0]     clr_cnt_r;
  logic [AW-1:0]     scan_cnt_r;
  logic              issuing_r;
  logic [CB-1:0]     q_ch_r [3];
  logic [RANK_W-1:0] q_rank_r;

  logic              s1_v_r;
  logic [AW-1:0]     s1_idx_r;

  logic              s2_v_r;
  logic              s2_same_r;
  logic [MW-1:0]     s2_m_r [3];
  logic [3*CB-1:0]   s2_rgb_r;
  logic [AW-1:0]     s2_idx_r;

  logic              s3_v_r;
  logic              s3_same_r;
  logic [DW-1:0]     s3_dist_r;
  logic [3*CB-1:0]   s3_rgb_r;
  logic [AW-1:0]     s3_idx_r;

  logic              all_v_r;
  logic [DW-1:0]     all_dist_r;
  logic [3*CB-1:0]   all_rgb_r;
  logic [AW-1:0]     all_idx_r;
  logic              same_v_r;
  logic [DW-1:0]     same_dist_r;
  logic [3*CB-1:0]   same_rgb_r;
  logic [AW-1:0]     same_idx_r;

  logic              out_valid_r;
  logic [INDEX_W-1:0] out_index_r;
  logic [3*CB-1:0]   out_rgb_r;
  logic              out_found_r;
  logic              out_same_r;

  logic              in_acc;
  logic              wr_acc;
  logic              q_acc;
  logic              wr_in_range;
  logic              pipe_empty;
  logic              out_free;

  logic [CB-1:0]     e_ch [3];
  logic [MW-1:0]     m_nxt [3];
  logic              same_nxt;
  logic [DW-1:0]     dist_nxt;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign wr_acc        = in_acc && (in_chan.kind == KIND_WRITE);
  assign q_acc         = in_acc && (in_chan.kind == KIND_QUERY);
  assign wr_in_range   = int'(in_chan.entry_index) < PALETTE_DEPTH;
  assign pipe_empty    = !issuing_r && !s1_v_r && !s2_v_r && !s3_v_r;
  assign out_free      = !out_valid_r || out_chan.ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == AW'(PALETTE_DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_acc) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (pipe_empty) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = wr_acc && wr_in_range;
      mem_waddr = AW'(in_chan.entry_index);
      mem_wdata = {in_chan.entry_available, CB'(in_chan.red), CB'(in_chan.green),
                   CB'(in_chan.blue)};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[scan_cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r  <= 1'b0;
      scan_cnt_r <= '0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
    end else begin
      if (q_acc) begin
        issuing_r  <= 1'b1;
        scan_cnt_r <= '0;
      end else if (issuing_r) begin
        scan_cnt_r <= scan_cnt_r + AW'(1);
        if (scan_cnt_r == AW'(PALETTE_DEPTH - 1)) issuing_r <= 1'b0;
      end
      s1_v_r <= issuing_r;
      s2_v_r <= s1_v_r && rd_data_r[MEM_W-1];
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_acc) begin
      q_ch_r[0] <= CB'(in_chan.red);
      q_ch_r[1] <= CB'(in_chan.green);
      q_ch_r[2] <= CB'(in_chan.blue);
      q_rank_r  <= rank_code(CHAN_W'(CB'(in_chan.red)), CHAN_W'(CB'(in_chan.green)),
                             CHAN_W'(CB'(in_chan.blue)));
    end
  end

  assign e_ch[0] = rd_data_r[3*CB-1:2*CB];
  assign e_ch[1] = rd_data_r[2*CB-1:CB];
  assign e_ch[2] = rd_data_r[CB-1:0];

  always_comb begin
    logic signed [CB:0] diff;
    logic signed [CB:0] sh;
    logic signed [CB:0] mag;
    for (int k = 0; k < 3; k++) begin
      diff     = $signed({1'b0, q_ch_r[k]}) - $signed({1'b0, e_ch[k]});
      sh       = diff >>> DIST_SHIFT;
      mag      = sh[CB] ? -sh : sh;
      m_nxt[k] = mag[MW-1:0];
    end
    same_nxt = rank_code(CHAN_W'(e_ch[0]), CHAN_W'(e_ch[1]), CHAN_W'(e_ch[2])) == q_rank_r;
  end

  assign dist_nxt = DW'(SQW'(s2_m_r[0]) * SQW'(s2_m_r[0])) +
                    DW'(SQW'(s2_m_r[1]) * SQW'(s2_m_r[1])) +
                    DW'(SQW'(s2_m_r[2]) * SQW'(s2_m_r[2]));

  always_ff @(posedge clk) begin
    s1_idx_r  <= scan_cnt_r;
    s2_m_r    <= m_nxt;
    s2_same_r <= same_nxt;
    s2_rgb_r  <= rd_data_r[3*CB-1:0];
    s2_idx_r  <= s1_idx_r;
    s3_dist_r <= dist_nxt;
    s3_same_r <= s2_same_r;
    s3_rgb_r  <= s2_rgb_r;
    s3_idx_r  <= s2_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_v_r  <= 1'b0;
      same_v_r <= 1'b0;
    end else if (q_acc) begin
      all_v_r  <= 1'b0;
      same_v_r <= 1'b0;
    end else if (s3_v_r) begin
      if (!all_v_r || s3_dist_r < all_dist_r) all_v_r <= 1'b1;
      if (s3_same_r && (!same_v_r || s3_dist_r < same_dist_r)) same_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && (!all_v_r || s3_dist_r < all_dist_r)) begin
      all_dist_r <= s3_dist_r;
      all_rgb_r  <= s3_rgb_r;
      all_idx_r  <= s3_idx_r;
    end
    if (s3_v_r && s3_same_r && (!same_v_r || s3_dist_r < same_dist_r)) begin
      same_dist_r <= s3_dist_r;
      same_rgb_r  <= s3_rgb_r;
      same_idx_r  <= s3_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      if (same_v_r) begin
        out_index_r <= INDEX_W'(same_idx_r);
        out_rgb_r   <= same_rgb_r;
      end else if (all_v_r) begin
        out_index_r <= INDEX_W'(all_idx_r);
        out_rgb_r   <= all_rgb_r;
      end else begin
        out_index_r <= '0;
        out_rgb_r   <= '0;
      end
      out_found_r <= same_v_r || all_v_r;
      out_same_r  <= same_v_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.match_index = out_index_r;
  assign out_chan.match_red   = CHAN_W'(out_rgb_r[3*CB-1:2*CB]);
  assign out_chan.match_green = CHAN_W'(out_rgb_r[2*CB-1:CB]);
  assign out_chan.match_blue  = CHAN_W'(out_rgb_r[CB-1:0]);
  assign out_chan.found       = out_found_r;
  assign out_chan.same_order  = out_same_r;

endmodule

`default_nettype wire

// ===== bench/nearest_palette_color_match_unit_tb.sv =====
// Self-checking testbench of the nearest palette color match unit.
// Depends on npcm_pkg, on npcm_in_if and npcm_out_if, and on the unit itself.
// A directed table runs first, then random scenes checked against a palette predictor.

module nearest_palette_color_match_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import npcm_pkg::*;

  localparam int NUM_SLOTS      = PALETTE_DEPTH_DEF;
  localparam int DIST_START     = 32'h0fff_ffff;
  localparam int TABLE_ROWS     = 24;
  localparam int HOLD_CYCLES    = 1200;
  localparam int WATCHDOG_LIMIT = 8000;
  localparam int DRAIN_CYCLES   = 300;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  typedef struct packed {
    kind_t              kind;
    logic [INDEX_W-1:0] idx;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
    logic               avail;
  } color_request_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [CHAN_W-1:0]  r;
    logic [CHAN_W-1:0]  g;
    logic [CHAN_W-1:0]  b;
    logic               found;
    logic               same;
  } color_match_t;

  typedef struct packed {
    color_request_t req;
    logic           typed;
    color_match_t   want;
  } color_row_t;

  localparam color_match_t NO_MATCH = '0;

  logic clk;
  logic rst_n;

  npcm_in_if  in_ch();
  npcm_out_if out_ch();

  nearest_palette_color_match_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  rgb_t               shadow_rgb [NUM_SLOTS] = '{default: '0};
  logic               shadow_usable [NUM_SLOTS] = '{default: 1'b0};
  logic [INDEX_W-1:0] last_slot = '0;
  color_match_t       expected_matches [$];
  int                 items_sent = 0;
  int                 errors = 0;
  logic               tx_idle_on = 1'b0;
  logic               rx_idle_on = 1'b0;
  logic               hold_results = 1'b0;

  color_row_t request_table [TABLE_ROWS] = '{
    '{'{KIND_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1, NO_MATCH},
    '{'{KIND_QUERY, 8'hff, 16'hffff, 16'hffff, 16'hffff, 1'b1}, 1'b1, NO_MATCH},
    '{'{KIND_WRITE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'hffff, 16'hffff, 16'hffff, 1'b0}, 1'b1,
      '{8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1}},
    '{'{KIND_WRITE, 8'hff, 16'hffff, 16'h0000, 16'h0000, 1'b1}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'hffff, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{8'hff, 16'hffff, 16'h0000, 16'h0000, 1'b1, 1'b1}},
    '{'{KIND_QUERY, 8'h00, 16'h0000, 16'hffff, 16'h0000, 1'b0}, 1'b1,
      '{8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0}},
    '{'{KIND_WRITE, 8'h00, 16'h1234, 16'h5678, 16'h9abc, 1'b0}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b0}, 1'b1,
      '{8'hff, 16'hffff, 16'h0000, 16'h0000, 1'b1, 1'b0}},
    '{'{KIND_WRITE, 8'hff, 16'hffff, 16'h0000, 16'h0000, 1'b0}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'hffff, 16'hffff, 16'hffff, 1'b1}, 1'b1, NO_MATCH},
    '{'{KIND_WRITE, 8'h0a, 16'h1000, 16'h2000, 16'h3000, 1'b1}, 1'b0, NO_MATCH},
    '{'{KIND_WRITE, 8'h14, 16'h1000, 16'h2000, 16'h3000, 1'b1}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'h1000, 16'h2000, 16'h3000, 1'b0}, 1'b0, NO_MATCH},
    '{'{KIND_WRITE, 8'h28, 16'h0200, 16'h0200, 16'h0200, 1'b1}, 1'b0, NO_MATCH},
    '{'{KIND_WRITE, 8'h32, 16'h0300, 16'h0300, 16'h0300, 1'b1}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'h0280, 16'h0280, 16'h0280, 1'b0}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'h01ff, 16'h01ff, 16'h01ff, 1'b0}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'h0500, 16'h0500, 16'h0900, 1'b0}, 1'b0, NO_MATCH},
    '{'{KIND_WRITE, 8'h3c, 16'h0900, 16'h0500, 16'h0500, 1'b1}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'h0400, 16'h0400, 16'h0400, 1'b0}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'h0900, 16'h0100, 16'h0100, 1'b0}, 1'b0, NO_MATCH},
    '{'{KIND_WRITE, 8'h80, 16'h8000, 16'h7fff, 16'h8001, 1'b1}, 1'b0, NO_MATCH},
    '{'{KIND_QUERY, 8'h00, 16'h7fff, 16'h8000, 16'h8001, 1'b0}, 1'b0, NO_MATCH}
  };

  // Ranks of red, green and blue as {red, green, blue}, 1 for the largest. Ties fall
  // where the strict compares leave them.
  function automatic logic [5:0] gun_order(input rgb_t c);
    logic [2:0] cmp;
    cmp = {c.r > c.g, c.r > c.b, c.g > c.b};
    casez (cmp)
      3'b111:  return {2'd1, 2'd2, 2'd3};
      3'b110:  return {2'd1, 2'd3, 2'd2};
      3'b10?:  return {2'd2, 2'd3, 2'd1};
      3'b011:  return {2'd2, 2'd1, 2'd3};
      3'b001:  return {2'd3, 2'd1, 2'd2};
      default: return {2'd3, 2'd2, 2'd1};
    endcase
  endfunction

  // The difference is floored by the shift, so a small negative step costs one.
  function automatic int channel_term(input logic [CHAN_W-1:0] q, input logic [CHAN_W-1:0] e);
    int d;
    d = int'(q) - int'(e);
    d = d >>> DIST_SHIFT;
    return d * d;
  endfunction

  function automatic color_match_t predict_match(input rgb_t q);
    color_match_t res;
    int best_same;
    int best_any;
    int pick_same;
    int pick_any;
    int pick;
    int d;
    int i;
    logic [5:0] order;
    best_same = DIST_START;
    best_any  = DIST_START;
    pick_same = -1;
    pick_any  = -1;
    order = gun_order(q);
    for (i = 0; i < NUM_SLOTS; i++) begin
      if (shadow_usable[i]) begin
        d = channel_term(q.r, shadow_rgb[i].r) + channel_term(q.g, shadow_rgb[i].g) +
            channel_term(q.b, shadow_rgb[i].b);
        if (d < best_any) begin
          best_any = d;
          pick_any = i;
        end
        if (gun_order(shadow_rgb[i]) == order && d < best_same) begin
          best_same = d;
          pick_same = i;
        end
      end
    end
    res = NO_MATCH;
    pick = (pick_same >= 0) ? pick_same : pick_any;
    if (pick >= 0) begin
      res = '{INDEX_W'(pick), shadow_rgb[pick].r, shadow_rgb[pick].g, shadow_rgb[pick].b,
              1'b1, pick_same >= 0};
    end
    return res;
  endfunction

  function automatic color_request_t random_request(input int query_pct);
    color_request_t req;
    rgb_t near;
    logic [CHAN_W-1:0] v;
    req.kind  = ($urandom_range(0, 99) < query_pct) ? KIND_QUERY : KIND_WRITE;
    req.idx   = INDEX_W'($urandom);
    req.avail = ($urandom_range(0, 99) < 85);
    req.r     = CHAN_W'($urandom);
    req.g     = CHAN_W'($urandom);
    req.b     = CHAN_W'($urandom);
    v         = CHAN_W'($urandom);
    near      = shadow_rgb[($urandom_range(0, 1) != 0) ? int'(last_slot) :
                           $urandom_range(0, NUM_SLOTS - 1)];
    case ($urandom_range(0, 9))
      0: {req.r, req.g} = {v, v};
      1: {req.g, req.b} = {v, v};
      2: {req.r, req.b} = {v, v};
      3: {req.r, req.g, req.b} = {v, v, v};
      4: begin
        req.r = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
        req.g = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
        req.b = ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
      end
      5, 6, 7, 8: begin
        req.r = near.r + CHAN_W'($urandom_range(0, 600) - 300);
        req.g = near.g + CHAN_W'($urandom_range(0, 600) - 300);
        req.b = near.b + CHAN_W'($urandom_range(0, 600) - 300);
      end
      default: ;
    endcase
    return req;
  endfunction

  task automatic record_request(input color_request_t req, input logic typed,
                                input color_match_t want);
    if (req.kind == KIND_WRITE) begin
      shadow_rgb[req.idx]    = '{req.r, req.g, req.b};
      shadow_usable[req.idx] = req.avail;
      last_slot              = req.idx;
    end else begin
      expected_matches.push_back(typed ? want : predict_match('{req.r, req.g, req.b}));
    end
    items_sent++;
  endtask

  task automatic send_request(input color_request_t req, input logic typed,
                              input color_match_t want);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.kind            <= req.kind;
    in_ch.entry_index     <= req.idx;
    in_ch.red             <= req.r;
    in_ch.green           <= req.g;
    in_ch.blue            <= req.b;
    in_ch.entry_available <= req.avail;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    record_request(req, typed, want);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_matches.size() != 0);
  endtask

  // A scene may first empty the palette, then writes land in a window of slots so that
  // sparse palettes reach the fallback pass and the empty case.
  task automatic run_scene(input int n_items, input int query_pct);
    color_request_t req;
    int base;
    int span;
    int s;
    int n;
    if ($urandom_range(0, 1) == 0) begin
      for (s = 0; s < NUM_SLOTS; s++) begin
        if (shadow_usable[s]) begin
          req       = random_request(0);
          req.idx   = INDEX_W'(s);
          req.avail = 1'b0;
          send_request(req, 1'b0, NO_MATCH);
        end
      end
    end
    base = $urandom_range(0, NUM_SLOTS - 1);
    case ($urandom_range(0, 2))
      0:       span = 7;
      1:       span = 31;
      default: span = NUM_SLOTS - 1;
    endcase
    for (n = 0; n < n_items; n++) begin
      req = random_request(query_pct);
      if (req.kind == KIND_WRITE) begin
        req.idx = INDEX_W'(base + $urandom_range(0, span));
      end
      send_request(req, 1'b0, NO_MATCH);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    color_match_t got;
    color_match_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = '{out_ch.match_index, out_ch.match_red, out_ch.match_green, out_ch.match_blue,
              out_ch.found, out_ch.same_order};
      if (expected_matches.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: idx=%0d rgb=%h/%h/%h found=%b same=%b",
                   got.idx, got.r, got.g, got.b, got.found, got.same);
        end
      end else begin
        want = expected_matches.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("result mismatch: expected idx=%0d rgb=%h/%h/%h found=%b same=%b",
                     want.idx, want.r, want.g, want.b, want.found, want.same);
            $display("                 actual   idx=%0d rgb=%h/%h/%h found=%b same=%b",
                     got.idx, got.r, got.g, got.b, got.found, got.same);
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int row;
    rst_n                 <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.kind            <= KIND_WRITE;
    in_ch.entry_index     <= '0;
    in_ch.red             <= '0;
    in_ch.green           <= '0;
    in_ch.blue            <= '0;
    in_ch.entry_available <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < TABLE_ROWS; row++) begin
      send_request(request_table[row].req, request_table[row].typed, request_table[row].want);
    end
    drain_results();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    while (items_sent < 500) begin
      run_scene($urandom_range(20, 80), 45);
    end

    // The result side stalls while requests keep coming, so the unit fills and backs up.
    hold_results = 1'b1;
    run_scene(40, 60);
    drain_results();

    while (items_sent < 1250) begin
      tx_idle_on = ($urandom_range(0, 2) != 0);
      rx_idle_on = ($urandom_range(0, 2) != 0);
      run_scene($urandom_range(20, 80), 45);
    end

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (items_sent < 1450) begin
      run_scene($urandom_range(20, 80), 45);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== nearest_palette_color_match_unit.f =====
hw/rtl/npcm_pkg.sv
hw/rtl/npcm_if.sv
hw/rtl/nearest_palette_color_match_unit.sv
bench/nearest_palette_color_match_unit_tb.sv
